@@ src/pcorr_pkg.sv @@
// Package for the Pearson correlation unit: widths, defaults and shared command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcorr_pkg;
    localparam int MAX_PAIRS_LOG2_DEF = 16;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_BITS          = 16;
    localparam int COUNT_BITS         = 17;
    localparam int KBITS              = 15;
    localparam int VBITS              = 64;
    localparam int PBITS              = 128;
    localparam int QBITS              = 192;
    localparam int ACC_BITS           = 48;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_VX_A,
        OP_VX_B,
        OP_VY_A,
        OP_VY_B,
        OP_CU_A,
        OP_CU_B,
        OP_PROD,
        OP_RHS,
        OP_TRY,
        OP_TRY_CMP
    } op_t;

    typedef struct packed {
        logic accum;
        logic clear;
        logic start;
        op_t  op;
        logic [KBITS-1:0] trial;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_var;
        logic trial_ok;
        logic busy;
    } dp_stat_t;
endpackage
`default_nettype wire

@@ src/pearson_correlation_unit.sv @@
// After the transfer of the final pair the result is shown once six passes of the shared
// 32 by 32 bit multiplier, a check, two more passes and a 15-step bitwise root search (a
// multiplier pass and a compare per step) are done, or after the check alone when a
// variance term is zero. The result then waits for its transfer.
// Throughput: one pair per cycle within a set; no pair is taken until the result is taken.
// Reset (rst_n, asynchronous, active low) clears all sums, the count and the controller.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_unit #(
    parameter int MAX_PAIRS_LOG2 = pcorr_pkg::MAX_PAIRS_LOG2_DEF,
    parameter int SAMPLE_BITS    = pcorr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] x_sample,
    input  wire logic signed [15:0] y_sample,
    input  wire logic               last_sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      coefficient,
    output logic                    undefined,
    output logic [16:0]             pair_count
);
    pcorr_pkg::dp_cmd_t cmd;
    pcorr_pkg::dp_stat_t stat;
    logic [MAX_PAIRS_LOG2:0] count_reg;
    logic neg_reg;
    logic [pcorr_pkg::KBITS-1:0] kmax;

    pcorr_datapath #(.MAX_PAIRS_LOG2(MAX_PAIRS_LOG2), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .x_sample(x_sample), .y_sample(y_sample),
        .stat(stat), .count_reg(count_reg), .neg_reg(neg_reg), .kmax(kmax)
    );

    pcorr_ctrl #(.MAX_PAIRS_LOG2(MAX_PAIRS_LOG2)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .last_sample(last_sample), .out_valid(out_valid), .out_ready(out_ready),
        .coefficient(coefficient), .undefined(undefined), .pair_count(pair_count),
        .cmd(cmd), .stat(stat), .count_reg(count_reg), .neg_reg(neg_reg), .kmax(kmax)
    );
endmodule
`default_nettype wire

@@ src/pcorr_datapath.sv @@
// Datapath of the Pearson correlation unit: accumulators and a shared multiplier unit.
// Depends on pcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcorr_datapath #(
    parameter int MAX_PAIRS_LOG2 = pcorr_pkg::MAX_PAIRS_LOG2_DEF,
    parameter int SAMPLE_BITS    = pcorr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pcorr_pkg::dp_cmd_t                 cmd,
    input  wire logic signed [15:0]                 x_sample,
    input  wire logic signed [15:0]                 y_sample,
    output pcorr_pkg::dp_stat_t                     stat,
    output logic [MAX_PAIRS_LOG2:0]                 count_reg,
    output logic                                    neg_reg,
    output logic [pcorr_pkg::KBITS-1:0]             kmax
);
    localparam int SB = SAMPLE_BITS;
    localparam int CB = MAX_PAIRS_LOG2 + 1;
    localparam int VB = pcorr_pkg::VBITS;
    localparam int PB = pcorr_pkg::PBITS;
    localparam int QB = pcorr_pkg::QBITS;
    localparam int AB = pcorr_pkg::ACC_BITS;
    localparam int KB = pcorr_pkg::KBITS;

    logic signed [SB-1:0] xs, ys;
    logic signed [2*SB-1:0] xx, yy, xy;
    logic signed [AB-1:0] sx_reg, sy_reg, sxx_reg, syy_reg, sxy_reg;
    logic [VB-1:0] nn, sx_w, sy_w, sxx_w, syy_w, sxy_w;
    logic [VB-1:0] vx_reg, vy_reg, mag_reg, mb_reg;
    logic [PB-1:0] prod_reg, ma_reg;
    logic [QB-1:0] acc_reg, rhs_reg, term, acc_sum;
    logic [2*KB-1:0] ksq;
    logic [31:0] a_limb, b_limb;
    logic [63:0] pp, pp_reg;
    logic [2:0] step_reg, psum, psum_reg;
    logic run_reg, pp_vld_reg, pp_last_reg, sub_reg;
    pcorr_pkg::op_t op_reg;

    assign xs = x_sample[SB-1:0];
    assign ys = y_sample[SB-1:0];
    assign xx = xs * xs;
    assign yy = ys * ys;
    assign xy = xs * ys;
    assign nn = VB'(count_reg);
    assign sx_w  = VB'(sx_reg);
    assign sy_w  = VB'(sy_reg);
    assign sxx_w = VB'(sxx_reg);
    assign syy_w = VB'(syy_reg);
    assign sxy_w = VB'(sxy_reg);
    assign ksq = cmd.trial * cmd.trial;

    // One 32 by 32 bit limb product per cycle, registered and then added into the wide accumulator.
    assign a_limb = ma_reg[{step_reg[2:1], 5'b0} +: 32];
    assign b_limb = mb_reg[{step_reg[0], 5'b0} +: 32];
    assign pp = a_limb * b_limb;
    assign psum = 3'(step_reg[2:1]) + 3'(step_reg[0]);
    assign term = QB'(pp_reg) << {psum_reg, 5'b0};
    assign acc_sum = sub_reg ? (acc_reg - term) : (acc_reg + term);

    assign stat.zero_var = (vx_reg == '0) || (vy_reg == '0);
    assign stat.trial_ok = acc_reg <= rhs_reg;
    assign stat.busy = run_reg || pp_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.accum)
        begin
            count_reg <= count_reg + CB'(1);
            sx_reg    <= sx_reg + AB'(xs);
            sy_reg    <= sy_reg + AB'(ys);
            sxx_reg   <= sxx_reg + AB'(xx);
            syy_reg   <= syy_reg + AB'(yy);
            sxy_reg   <= sxy_reg + AB'(xy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            run_reg     <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
        end
        else
        begin
            pp_vld_reg  <= run_reg;
            pp_last_reg <= run_reg && (step_reg == 3'd7);
            if (cmd.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            pp_reg   <= pp;
            psum_reg <= psum;
        end
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            sub_reg <= cmd.op inside {pcorr_pkg::OP_VX_B, pcorr_pkg::OP_VY_B,
                                      pcorr_pkg::OP_CU_B};
            if (!(cmd.op inside {pcorr_pkg::OP_VX_B, pcorr_pkg::OP_VY_B,
                                 pcorr_pkg::OP_CU_B}))
            begin
                acc_reg <= '0;
            end
            case (cmd.op)
                pcorr_pkg::OP_VX_A:
                begin
                    ma_reg <= PB'(nn);
                    mb_reg <= sxx_w;
                end
                pcorr_pkg::OP_VX_B:
                begin
                    ma_reg <= PB'(sx_w);
                    mb_reg <= sx_w;
                end
                pcorr_pkg::OP_VY_A:
                begin
                    ma_reg <= PB'(nn);
                    mb_reg <= syy_w;
                end
                pcorr_pkg::OP_VY_B:
                begin
                    ma_reg <= PB'(sy_w);
                    mb_reg <= sy_w;
                end
                pcorr_pkg::OP_CU_A:
                begin
                    ma_reg <= PB'(nn);
                    mb_reg <= sxy_w;
                end
                pcorr_pkg::OP_CU_B:
                begin
                    ma_reg <= PB'(sx_w);
                    mb_reg <= sy_w;
                end
                pcorr_pkg::OP_PROD:
                begin
                    ma_reg <= PB'(vx_reg);
                    mb_reg <= vy_reg;
                end
                pcorr_pkg::OP_RHS:
                begin
                    ma_reg <= PB'(mag_reg);
                    mb_reg <= mag_reg;
                end
                pcorr_pkg::OP_TRY:
                begin
                    ma_reg <= prod_reg;
                    mb_reg <= VB'(ksq);
                end
                default:
                begin
                    ma_reg <= '0;
                    mb_reg <= '0;
                end
            endcase
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pp_vld_reg && pp_last_reg)
        begin
            case (op_reg)
                pcorr_pkg::OP_VX_B: vx_reg <= acc_sum[VB-1:0];
                pcorr_pkg::OP_VY_B: vy_reg <= acc_sum[VB-1:0];
                pcorr_pkg::OP_CU_B:
                begin
                    neg_reg <= acc_sum[VB-1];
                    mag_reg <= acc_sum[VB-1] ? (VB'(0) - acc_sum[VB-1:0]) : acc_sum[VB-1:0];
                    kmax    <= '0;
                end
                pcorr_pkg::OP_PROD: prod_reg <= acc_sum[PB-1:0];
                pcorr_pkg::OP_RHS:  rhs_reg <= acc_sum << 30;
                default:
                begin
                end
            endcase
        end
        else if (cmd.op == pcorr_pkg::OP_TRY_CMP && stat.trial_ok)
        begin
            kmax <= cmd.trial;
        end
    end
endmodule
`default_nettype wire

@@ src/pcorr_ctrl.sv @@
// Controller of the Pearson correlation unit: sequences accumulation, the variance
// terms and the bitwise root search; holds the output register. Depends on pcorr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcorr_ctrl #(
    parameter int MAX_PAIRS_LOG2 = pcorr_pkg::MAX_PAIRS_LOG2_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       last_sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [15:0]              coefficient,
    output logic                            undefined,
    output logic [16:0]                     pair_count,
    output pcorr_pkg::dp_cmd_t              cmd,
    input  wire pcorr_pkg::dp_stat_t        stat,
    input  wire logic [MAX_PAIRS_LOG2:0]    count_reg,
    input  wire logic                       neg_reg,
    input  wire logic [pcorr_pkg::KBITS-1:0] kmax
);
    localparam int KB = pcorr_pkg::KBITS;
    typedef enum logic [3:0] {
        S_ACC, S_VX_A, S_VX_B, S_VY_A, S_VY_B, S_CU_A, S_CU_B, S_CHK,
        S_PROD, S_RHS, S_TRY, S_CMP, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [KB-1:0] bit_reg, trial;
    logic set_end;
    logic issued_reg;
    logic op_done;
    logic [MAX_PAIRS_LOG2:0] full;

    assign full = {1'b1, {MAX_PAIRS_LOG2{1'b0}}};
    assign trial = kmax | bit_reg;
    assign in_ready = (state_reg == S_ACC);
    assign set_end = last_sample || (count_reg == full - 1'b1);
    assign op_done = issued_reg && !stat.busy;

    always_comb
    begin
        cmd.accum = in_valid && in_ready;
        cmd.clear = 1'b0;
        cmd.start = 1'b0;
        cmd.trial = trial;
        case (state_reg)
            S_VX_A: cmd.op = pcorr_pkg::OP_VX_A;
            S_VX_B: cmd.op = pcorr_pkg::OP_VX_B;
            S_VY_A: cmd.op = pcorr_pkg::OP_VY_A;
            S_VY_B: cmd.op = pcorr_pkg::OP_VY_B;
            S_CU_A: cmd.op = pcorr_pkg::OP_CU_A;
            S_CU_B: cmd.op = pcorr_pkg::OP_CU_B;
            S_PROD: cmd.op = pcorr_pkg::OP_PROD;
            S_RHS:  cmd.op = pcorr_pkg::OP_RHS;
            S_TRY:  cmd.op = pcorr_pkg::OP_TRY;
            S_CMP:  cmd.op = pcorr_pkg::OP_TRY_CMP;
            default: cmd.op = pcorr_pkg::OP_NONE;
        endcase
        if (state_reg inside {S_VX_A, S_VX_B, S_VY_A, S_VY_B, S_CU_A, S_CU_B,
                              S_PROD, S_RHS, S_TRY})
        begin
            cmd.start = !issued_reg;
        end
        if (state_reg == S_CHK && stat.zero_var)
        begin
            cmd.clear = 1'b1;
        end
        if (state_reg == S_DONE)
        begin
            cmd.clear = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACC;
            issued_reg  <= 1'b0;
            out_valid   <= 1'b0;
            bit_reg     <= '0;
            coefficient <= '0;
            undefined   <= 1'b0;
            pair_count  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (op_done)
            begin
                issued_reg <= 1'b0;
            end
            case (state_reg)
                S_ACC:
                begin
                    if (in_valid && set_end)
                    begin
                        state_reg <= S_VX_A;
                    end
                end
                S_VX_A: if (op_done) state_reg <= S_VX_B;
                S_VX_B: if (op_done) state_reg <= S_VY_A;
                S_VY_A: if (op_done) state_reg <= S_VY_B;
                S_VY_B: if (op_done) state_reg <= S_CU_A;
                S_CU_A: if (op_done) state_reg <= S_CU_B;
                S_CU_B: if (op_done) state_reg <= S_CHK;
                S_CHK:
                begin
                    pair_count <= 17'(count_reg);
                    if (stat.zero_var)
                    begin
                        coefficient <= '0;
                        undefined   <= 1'b1;
                        out_valid   <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_PROD;
                    end
                end
                S_PROD: if (op_done) state_reg <= S_RHS;
                S_RHS:
                begin
                    if (op_done)
                    begin
                        bit_reg   <= {1'b1, {(KB-1){1'b0}}};
                        state_reg <= S_TRY;
                    end
                end
                S_TRY:  if (op_done) state_reg <= S_CMP;
                S_CMP:
                begin
                    bit_reg <= bit_reg >> 1;
                    state_reg <= (bit_reg[0]) ? S_DONE : S_TRY;
                end
                S_DONE:
                begin
                    coefficient <= neg_reg ? (16'sd0 - 16'(kmax)) : 16'(kmax);
                    undefined   <= 1'b0;
                    out_valid   <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_ACC;
                    end
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/pcorr_checker.sv @@
// Port-level checker for the Pearson correlation unit, bound to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pcorr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] coefficient,
    input wire logic               undefined,
    input wire logic [16:0]        pair_count
);
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready while result pending");
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && undefined |-> coefficient == 16'sd0) else $error("undefined nonzero");
    a_count_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pair_count != 17'd0) else $error("empty set reported");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coefficient))
        else $error("result dropped");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid) else $error("input transfer withdrawn");
endmodule

bind pearson_correlation_unit pcorr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .coefficient(coefficient),
    .undefined(undefined), .pair_count(pair_count)
);
`default_nettype wire
